[design/http_response_framer_unit_assert.svh]
// Assertion macros for the HTTP response framer.
// Uses the clk and rst_n signals of the module that includes this header.
`ifndef HTTP_RESPONSE_FRAMER_UNIT_ASSERT_SVH
`define HTTP_RESPONSE_FRAMER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define HRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed: next-cycle implication");

`endif

[design/hrf_pkg.sv]
// Package for the HTTP response framer: widths, characters and the result record.
// Has no dependencies; used by the channel interfaces and the top level.
`default_nettype none

package hrf_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int COUNT_BITS  = 32;
    localparam int OUT_BITS    = 32;
    localparam int NAME_LEN    = 14;
    localparam int POS_BITS    = $clog2(NAME_LEN + 1);
    localparam int CMP_BITS    = (LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef logic [POS_BITS-1:0] name_pos_t;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic                byte_class;
        logic                header_done;
        logic                length_known;
        logic                length_negative;
        logic [OUT_BITS-1:0] content_length;
        logic [OUT_BITS-1:0] body_count;
        logic                complete;
        logic                unterminated;
        logic                last;
    } result_t;

    // Lower-case letters of the field name being searched for.
    function automatic logic [7:0] name_char(input name_pos_t pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[design/hrf_in_if.sv]
// Input channel of the framer: one stream byte and its end-of-stream mark per beat.
// Depends on hrf_pkg.
`default_nettype none

interface hrf_in_if;
    import hrf_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

[design/hrf_out_if.sv]
// Output channel of the framer: the passed byte and its framing status per beat.
// Depends on hrf_pkg.
`default_nettype none

interface hrf_out_if;
    import hrf_pkg::*;

    logic                valid;
    logic                ready;
    logic [7:0]          out_byte;
    logic                byte_class;
    logic                header_done;
    logic                length_known;
    logic                length_negative;
    logic [OUT_BITS-1:0] content_length;
    logic [OUT_BITS-1:0] body_count;
    logic                complete;
    logic                unterminated;
    logic                last;

    modport source (
        output valid, output out_byte, output byte_class, output header_done,
        output length_known, output length_negative, output content_length,
        output body_count, output complete, output unterminated, output last,
        input ready
    );
    modport sink (
        input valid, input out_byte, input byte_class, input header_done,
        input length_known, input length_negative, input content_length,
        input body_count, input complete, input unterminated, input last,
        output ready
    );
endinterface

`default_nettype wire

[design/http_response_framer_unit.sv]
// Channel   | Dir | Beat contents
// ----------+-----+------------------------------------------------------------
// rx        | in  | in_byte, end_of_stream
// tx        | out | out_byte, byte_class, header_done, length_known,
//           |     | length_negative, content_length, body_count, complete,
//           |     | unterminated, last
//
// One byte is taken per cycle while rx.ready is high; its status beat is registered
// in the output buffer and appears on tx from there. The parse state is updated in
// the cycle a byte is taken, so the terminator, name and digit logic never holds rx.
// A two-entry output buffer lets rx take one more byte while tx is stalled;
// rx.ready drops only when both entries are full.
// Reset clears all parse state and empties the output buffer.
//
// Depends on hrf_pkg, hrf_in_if, hrf_out_if and http_response_framer_unit_assert.svh.
`default_nettype none

module http_response_framer_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    hrf_in_if.sink    rx,
    hrf_out_if.source tx
);
    import hrf_pkg::*;

    typedef enum logic [2:0] {
        TERM_NONE,
        TERM_CR,
        TERM_CRLF,
        TERM_CRLFCR,
        TERM_LF
    } term_t;

    typedef enum logic [1:0] {
        PHASE_IDLE,
        PHASE_SEP,
        PHASE_SIGN,
        PHASE_DIGITS
    } phase_t;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [COUNT_BITS-1:0]  CNT_MAX = '1;

    term_t                  term_reg, term_next;
    logic                   header_seen_reg, header_seen_next;
    name_pos_t              name_pos_reg, name_pos_next;
    logic                   name_found_reg, name_found_next;
    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    logic                   minus_reg, minus_next;
    logic [COUNT_BITS-1:0]  body_cnt_reg, body_cnt_next;

    result_t out_reg, skid_reg, result;
    logic    out_valid_reg, skid_valid_reg;

    logic accept;
    logic take;

    logic [7:0]             ch;
    logic [7:0]             lower;
    logic                   done;
    logic                   is_ws;
    logic                   is_digit;
    logic [LENGTH_BITS+3:0] scaled;
    name_pos_t              pos;

    assign accept   = rx.valid && rx.ready;
    assign take     = tx.valid && tx.ready;
    assign rx.ready = !skid_valid_reg;

    assign ch       = rx.in_byte;
    assign lower    = (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ? ch + CASE_OFFSET : ch;
    assign is_ws    = (ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_LF)
                   || (ch == CHAR_VT) || (ch == CHAR_FF) || (ch == CHAR_CR);
    assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    // Ten times the length plus the digit, wide enough to see any overflow.
    assign scaled   = ({4'b0, length_reg} << 3) + ({4'b0, length_reg} << 1)
                    + (LENGTH_BITS + 4)'(ch - CHAR_ZERO);

    always_comb
    begin
        term_next        = term_reg;
        header_seen_next = header_seen_reg;
        name_pos_next    = name_pos_reg;
        name_found_next  = name_found_reg;
        phase_next       = phase_reg;
        length_next      = length_reg;
        minus_next       = minus_reg;
        body_cnt_next    = body_cnt_reg;
        pos              = name_pos_reg;

        if (header_seen_reg)
        begin
            if (body_cnt_reg != CNT_MAX)
                body_cnt_next = body_cnt_reg + 1'b1;
        end
        else
        begin
            if (name_found_reg)
            begin
                // The value parser falls through its phases within one byte.
                if (phase_next == PHASE_SEP)
                begin
                    if (!(ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_COLON))
                        phase_next = PHASE_SIGN;
                end
                if (phase_next == PHASE_SIGN && phase_reg != PHASE_IDLE
                    && !(phase_reg == PHASE_SEP
                         && (ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_COLON)))
                begin
                    if (is_ws)
                        phase_next = PHASE_SIGN;
                    else if (ch == CHAR_PLUS || ch == CHAR_MINUS)
                    begin
                        minus_next = (ch == CHAR_MINUS);
                        phase_next = PHASE_IDLE;
                    end
                    else
                        phase_next = PHASE_DIGITS;
                end
                if (phase_next == PHASE_IDLE && phase_reg != PHASE_IDLE)
                    phase_next = PHASE_DIGITS;
                else if (phase_next == PHASE_DIGITS)
                begin
                    if (is_digit)
                    begin
                        if (scaled[LENGTH_BITS+3:LENGTH_BITS] != 4'b0)
                            length_next = LEN_MAX;
                        else
                            length_next = scaled[LENGTH_BITS-1:0];
                    end
                    else
                        phase_next = PHASE_IDLE;
                end
            end
            else
            begin
                if (pos >= name_pos_t'(NAME_LEN))
                    pos = '0;
                if (lower == name_char(pos))
                    pos = pos + 1'b1;
                else
                    pos = (lower == name_char('0)) ? name_pos_t'(1) : '0;
                if (pos == name_pos_t'(NAME_LEN))
                begin
                    name_found_next = 1'b1;
                    phase_next      = PHASE_SEP;
                    pos             = '0;
                end
                name_pos_next = pos;
            end

            priority if (ch == CHAR_CR)
                term_next = (term_reg == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
            else if (ch == CHAR_LF)
            begin
                if (term_reg == TERM_CRLF || term_reg == TERM_CRLFCR || term_reg == TERM_LF)
                begin
                    term_next        = TERM_NONE;
                    header_seen_next = 1'b1;
                end
                else
                    term_next = (term_reg == TERM_CR) ? TERM_CRLF : TERM_LF;
            end
            else
                term_next = TERM_NONE;
        end

        done = header_seen_next && name_found_next
            && !(minus_next && length_next != '0)
            && (CMP_BITS'(body_cnt_next) >= CMP_BITS'(length_next));

        result.out_byte        = ch;
        result.byte_class      = header_seen_reg;
        result.header_done     = header_seen_next;
        result.length_known    = name_found_next;
        result.length_negative = minus_next;
        result.content_length  = OUT_BITS'(length_next);
        result.body_count      = OUT_BITS'(body_cnt_next);
        result.complete        = done;
        result.unterminated    = rx.end_of_stream && !header_seen_next;
        result.last            = rx.end_of_stream;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg        <= TERM_NONE;
            header_seen_reg <= 1'b0;
            name_pos_reg    <= '0;
            name_found_reg  <= 1'b0;
            phase_reg       <= PHASE_IDLE;
            length_reg      <= '0;
            minus_reg       <= 1'b0;
            body_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
            out_reg         <= '0;
            skid_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (rx.end_of_stream)
                begin
                    term_reg        <= TERM_NONE;
                    header_seen_reg <= 1'b0;
                    name_pos_reg    <= '0;
                    name_found_reg  <= 1'b0;
                    phase_reg       <= PHASE_IDLE;
                    length_reg      <= '0;
                    minus_reg       <= 1'b0;
                    body_cnt_reg    <= '0;
                end
                else
                begin
                    term_reg        <= term_next;
                    header_seen_reg <= header_seen_next;
                    name_pos_reg    <= name_pos_next;
                    name_found_reg  <= name_found_next;
                    phase_reg       <= phase_next;
                    length_reg      <= length_next;
                    minus_reg       <= minus_next;
                    body_cnt_reg    <= body_cnt_next;
                end
            end

            if (!out_valid_reg || take)
            begin
                if (skid_valid_reg)
                begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    if (accept)
                        out_reg <= result;
                    out_valid_reg <= accept;
                end
            end
            else if (accept)
            begin
                skid_reg       <= result;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign tx.valid           = out_valid_reg;
    assign tx.out_byte        = out_reg.out_byte;
    assign tx.byte_class      = out_reg.byte_class;
    assign tx.header_done     = out_reg.header_done;
    assign tx.length_known    = out_reg.length_known;
    assign tx.length_negative = out_reg.length_negative;
    assign tx.content_length  = out_reg.content_length;
    assign tx.body_count      = out_reg.body_count;
    assign tx.complete        = out_reg.complete;
    assign tx.unterminated    = out_reg.unterminated;
    assign tx.last            = out_reg.last;

`include "http_response_framer_unit_assert.svh"

    // The spare entry is only ever filled behind a waiting main entry.
    `HRF_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)

    // Once in the body, only an end-of-stream byte returns the parser to the header.
    `HRF_ASSERT_NEXT(a_body_sticky, accept && header_seen_reg && !rx.end_of_stream,
        header_seen_reg)

    // An end-of-stream byte leaves the parser fully cleared.
    `HRF_ASSERT_NEXT(a_eos_clears, accept && rx.end_of_stream,
        !header_seen_reg && !name_found_reg && body_cnt_reg == '0 && length_reg == '0)

    // A body byte can only be reported after the header has ended.
    `HRF_ASSERT_SAME(a_body_after_header, out_valid_reg && out_reg.byte_class,
        out_reg.header_done)

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for http_response_framer_unit: it streams response bytes on rx and
// checks every status beat on tx against a predictor kept inside the bench.
// Depends on hrf_pkg, hrf_in_if, hrf_out_if and the framer top level.

module tb;
    import hrf_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam logic [8*NAME_LEN-1:0] FIELD_NAME = "content-length";

    typedef enum logic [2:0] {TRK_NONE, TRK_CR, TRK_CRLF, TRK_CRLFCR, TRK_LF} term_track_t;
    typedef enum logic [1:0] {VAL_IDLE, VAL_SEP, VAL_SIGN, VAL_DIGITS} value_phase_t;

    logic clk = 1'b0;
    logic rst_n;

    hrf_in_if  rx_ch();
    hrf_out_if tx_ch();

    http_response_framer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    always #6 clk = ~clk;

    // Predicted framer state.
    term_track_t            trk      = TRK_NONE;
    logic                   hdr_seen = 1'b0;
    name_pos_t              name_pos = '0;
    logic                   name_hit = 1'b0;
    value_phase_t           vphase   = VAL_IDLE;
    logic [LENGTH_BITS-1:0] len_val  = '0;
    logic                   minus    = 1'b0;
    logic [COUNT_BITS-1:0]  body_cnt = '0;

    result_t    expected_beats[$];
    logic [7:0] stream_bytes[$];
    result_t    want;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_len      = 0;
    int hold_id       = 0;
    int hold_seen_id  = 0;
    int hold_left     = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int bytes_sent    = 0;
    int messages_sent = 0;
    int completes_seen    = 0;
    int unterminated_seen = 0;

    function automatic logic [7:0] field_char(input int i);
        return FIELD_NAME[8*(NAME_LEN-1-i) +: 8];
    endfunction

    // Advances the predicted state by one byte and returns the beat it should produce.
    function automatic result_t frame_byte(input logic [7:0] c, input logic eos);
        result_t                r;
        logic                   was_body;
        logic                   consumed;
        logic [7:0]             lc;
        name_pos_t              pos;
        logic [LENGTH_BITS+3:0] grown;
        was_body = hdr_seen;
        consumed = 1'b0;
        if (was_body)
        begin
            if (body_cnt != {COUNT_BITS{1'b1}})
                body_cnt = body_cnt + 1'b1;
        end
        else
        begin
            if (name_hit)
            begin
                // The value phases fall through into one another within the same byte.
                if (vphase == VAL_SEP)
                begin
                    if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_COLON)
                        consumed = 1'b1;
                    else
                        vphase = VAL_SIGN;
                end
                if (!consumed && vphase == VAL_SIGN)
                begin
                    if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_VT
                        || c == CHAR_FF || c == CHAR_CR)
                        consumed = 1'b1;
                    else if (c == CHAR_PLUS || c == CHAR_MINUS)
                    begin
                        minus = (c == CHAR_MINUS);
                        vphase = VAL_DIGITS;
                        consumed = 1'b1;
                    end
                    else
                        vphase = VAL_DIGITS;
                end
                if (!consumed && vphase == VAL_DIGITS)
                begin
                    if (c >= CHAR_ZERO && c <= CHAR_NINE)
                    begin
                        grown = {4'b0, len_val} * (LENGTH_BITS + 4)'(10)
                              + (LENGTH_BITS + 4)'(c - CHAR_ZERO);
                        if (grown[LENGTH_BITS+3:LENGTH_BITS] != 4'b0)
                            len_val = '1;
                        else
                            len_val = grown[LENGTH_BITS-1:0];
                    end
                    else
                        vphase = VAL_IDLE;
                end
            end
            else
            begin
                lc = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
                pos = name_pos;
                if (pos >= NAME_LEN)
                    pos = '0;
                if (lc == field_char(int'(pos)))
                    pos = pos + 1'b1;
                else if (lc == field_char(0))
                    pos = name_pos_t'(1);
                else
                    pos = '0;
                if (pos == NAME_LEN)
                begin
                    name_hit = 1'b1;
                    vphase = VAL_SEP;
                    pos = '0;
                end
                name_pos = pos;
            end

            if (c == CHAR_CR)
            begin
                if (trk == TRK_CRLF)
                    trk = TRK_CRLFCR;
                else
                    trk = TRK_CR;
            end
            else if (c == CHAR_LF)
            begin
                if (trk == TRK_CRLF || trk == TRK_CRLFCR || trk == TRK_LF)
                begin
                    trk = TRK_NONE;
                    hdr_seen = 1'b1;
                end
                else if (trk == TRK_CR)
                    trk = TRK_CRLF;
                else
                    trk = TRK_LF;
            end
            else
                trk = TRK_NONE;
        end

        r.out_byte        = c;
        r.byte_class      = was_body;
        r.header_done     = hdr_seen;
        r.length_known    = name_hit;
        r.length_negative = minus;
        r.content_length  = len_val[OUT_BITS-1:0];
        r.body_count      = body_cnt[OUT_BITS-1:0];
        r.complete        = hdr_seen && name_hit && !(minus && len_val != 0)
                            && body_cnt >= len_val;
        r.unterminated    = eos && !hdr_seen;
        r.last            = eos;

        if (eos)
        begin
            trk      = TRK_NONE;
            hdr_seen = 1'b0;
            name_pos = '0;
            name_hit = 1'b0;
            vphase   = VAL_IDLE;
            len_val  = '0;
            minus    = 1'b0;
            body_cnt = '0;
        end
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid         <= 1'b1;
        rx_ch.in_byte       <= b;
        rx_ch.end_of_stream <= eos;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        expected_beats.push_back(frame_byte(b, eos));
        bytes_sent++;
    endtask

    // Sends the assembled response, marking its final byte as the end of the stream.
    task automatic send_stream();
        int i;
        for (i = 0; i < stream_bytes.size(); i++)
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        messages_sent++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            stream_bytes.push_back(s[i]);
    endtask

    task automatic push_packed(input logic [127:0] v, input int n);
        int i;
        for (i = 0; i < n; i++)
            stream_bytes.push_back(v[8*(n-1-i) +: 8]);
    endtask

    task automatic push_line_end();
        if ($urandom_range(1))
            stream_bytes.push_back(CHAR_CR);
        stream_bytes.push_back(CHAR_LF);
    endtask

    task automatic push_junk_line();
        repeat ($urandom_range(5, 1))
            stream_bytes.push_back(8'(8'h61 + $urandom_range(25)));
        push_text(": 1");
        push_line_end();
    endtask

    // Appends a length field line in one of its many spellings; returns a body size to aim at.
    task automatic push_length_field(output int body_hint);
        int         i;
        logic [7:0] ch;
        case ($urandom_range(3))
            1: push_text("c");
            2: push_text("conte");
            3: push_text("content-");
            default: ;
        endcase
        for (i = 0; i < NAME_LEN; i++)
        begin
            ch = field_char(i);
            if (ch != CHAR_MINUS && $urandom_range(1))
                ch = ch - CASE_OFFSET;
            stream_bytes.push_back(ch);
        end
        repeat ($urandom_range(3))
        begin
            case ($urandom_range(2))
                0: stream_bytes.push_back(CHAR_SPACE);
                1: stream_bytes.push_back(CHAR_TAB);
                default: stream_bytes.push_back(CHAR_COLON);
            endcase
        end
        repeat ($urandom_range(2))
        begin
            case ($urandom_range(3))
                0: stream_bytes.push_back(CHAR_SPACE);
                1: stream_bytes.push_back(CHAR_TAB);
                2: stream_bytes.push_back(CHAR_VT);
                default: stream_bytes.push_back(CHAR_FF);
            endcase
        end
        case ($urandom_range(9))
            0: stream_bytes.push_back(CHAR_PLUS);
            1: stream_bytes.push_back(CHAR_MINUS);
            default: ;
        endcase
        body_hint = 0;
        case ($urandom_range(9))
            0: ;
            1: repeat ($urandom_range(2, 1)) stream_bytes.push_back(CHAR_ZERO);
            6: repeat ($urandom_range(14, 10))
                   stream_bytes.push_back(8'(CHAR_ZERO + $urandom_range(9)));
            7:
            begin
                case ($urandom_range(2))
                    0: push_text("4294967294");
                    1: push_text("4294967295");
                    default: push_text("4294967296");
                endcase
            end
            default:
            begin
                body_hint = $urandom_range(30, 1);
                push_text($sformatf("%0d", body_hint));
            end
        endcase
        if ($urandom_range(4) == 0)
            push_text(";x");
        push_line_end();
    endtask

    // Mostly well-formed responses with random content; some noise and some cut short.
    task automatic build_message();
        int kind;
        int n;
        int hint;
        int ignored;
        stream_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            repeat ($urandom_range(20, 1))
            begin
                case ($urandom_range(3))
                    0: stream_bytes.push_back(CHAR_CR);
                    1: stream_bytes.push_back(CHAR_LF);
                    default: stream_bytes.push_back(8'($urandom_range(255)));
                endcase
            end
        end
        else
        begin
            hint = 0;
            repeat ($urandom_range(2))
                push_junk_line();
            if ($urandom_range(9) != 0)
                push_length_field(hint);
            // A second length field must be ignored.
            if ($urandom_range(4) == 0)
                push_length_field(ignored);
            if ($urandom_range(3) == 0)
                push_junk_line();
            push_line_end();
            if (hint != 0 && $urandom_range(3) != 0)
                n = hint - 1 + $urandom_range(3);
            else
                n = $urandom_range(12);
            repeat (n)
            begin
                if ($urandom_range(1))
                    stream_bytes.push_back(8'(CHAR_ZERO + $urandom_range(9)));
                else
                    stream_bytes.push_back(8'($urandom_range(255)));
            end
            if (kind < 27)
            begin
                n = $urandom_range(stream_bytes.size(), 1);
                while (stream_bytes.size() > n)
                    void'(stream_bytes.pop_back());
            end
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", field, exp_v, act_v);
            error_count++;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    always @(posedge clk)
    begin
        if (hold_id != hold_seen_id)
        begin
            hold_seen_id = hold_id;
            hold_left = hold_len;
        end
        if (!rst_n)
            tx_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            tx_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            tx_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: out_byte %0h", tx_ch.out_byte);
                error_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("out_byte", want.out_byte, tx_ch.out_byte);
                check_field("byte_class", want.byte_class, tx_ch.byte_class);
                check_field("header_done", want.header_done, tx_ch.header_done);
                check_field("length_known", want.length_known, tx_ch.length_known);
                check_field("length_negative", want.length_negative, tx_ch.length_negative);
                check_field("content_length", want.content_length, tx_ch.content_length);
                check_field("body_count", want.body_count, tx_ch.body_count);
                check_field("complete", want.complete, tx_ch.complete);
                check_field("unterminated", want.unterminated, tx_ch.unterminated);
                check_field("last", want.last, tx_ch.last);
                if (want.complete)
                    completes_seen++;
                if (want.unterminated)
                    unterminated_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Both terminator kinds, mixed CR and LF runs, zero and all-ones bytes, unterminated streams.
    task automatic test_terminators();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        stream_bytes.delete();
        push_packed(128'({8'h41, CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF, 8'h42}), 6);
        send_stream();
        stream_bytes.delete();
        push_packed(128'({CHAR_LF, CHAR_LF, 8'h00}), 3);
        send_stream();
        stream_bytes.delete();
        push_packed(128'({CHAR_CR, CHAR_CR, CHAR_LF, CHAR_LF}), 4);
        send_stream();
        stream_bytes.delete();
        push_packed(128'({CHAR_CR, CHAR_LF, CHAR_CR, CHAR_CR, CHAR_LF, CHAR_LF}), 6);
        send_stream();
        stream_bytes.delete();
        push_packed(128'({8'hFF, 8'h00, CHAR_CR, CHAR_LF}), 4);
        send_stream();
        stream_bytes.delete();
        push_packed(128'({8'h5A}), 1);
        send_stream();
    endtask

    task automatic test_random_responses(input int src_pct, input int sink_pct, input int target);
        int goal;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        goal = bytes_sent + target;
        while (bytes_sent < goal)
        begin
            build_message();
            send_stream();
        end
    endtask

    // The receiver stops for a long stretch while bytes keep coming, so rx must stall.
    task automatic test_output_hold_off();
        int goal;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        hold_len = HOLD_OFF_CYCLES;
        hold_id++;
        goal = bytes_sent + 60;
        while (bytes_sent < goal)
        begin
            build_message();
            send_stream();
        end
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        rx_ch.valid         <= 1'b0;
        rx_ch.in_byte       <= 8'h00;
        rx_ch.end_of_stream <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_terminators();
        test_random_responses(27, 61, 520);
        test_random_responses(61, 27, 520);
        test_random_responses(0, 0, 480);
        test_output_hold_off();

        rx_ch.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d responses (%0d bytes) under three idling mixes and one long hold-off.",
                 messages_sent, bytes_sent);
        $display("Beats flagged complete: %0d, unterminated ends: %0d.",
                 completes_seen, unterminated_seen);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/hrf_pkg.sv
design/hrf_in_if.sv
design/hrf_out_if.sv
design/http_response_framer_unit.sv
verif/tb.sv
